/* sv/mlst_pkg.sv */
package mlst_pkg;

  localparam int NUM_PORTS        = 8;
  localparam int ENTRIES_PER_PORT = 8;
  localparam int TIME_BITS        = 32;
  localparam int PORT_W           = 3;
  localparam int SLOT_W           = 3;
  localparam int MAC_W            = 48;
  localparam int LEN_W            = 13;
  localparam int KIND_W           = 3;
  localparam int CFG_W            = 16;
  localparam int MIN_FRAME_BYTES  = 14;
  localparam int DEFAULT_EXPIRE   = 60 * 60;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [MAC_W-1:0]     BCAST_MAC = '1;
  localparam logic [TIME_BITS-1:0] TIME_MAX  = '1;

  localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PORT   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_HOST   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ATTACH = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DETACH = 3'd4;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_RUNT   = 3'd1,
    ST_FULL   = 3'd2,
    ST_NODEST = 3'd3,
    ST_ABSENT = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_TICK,
    OP_LEARN,
    OP_FLOOD,
    OP_ATTACH,
    OP_DETACH,
    OP_RUNT,
    OP_ABSENT
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_LEARN,
    S_FLOOD,
    S_DONE
  } state_e;

  typedef struct packed {
    op_e               op;
    logic              runt;
    logic [PORT_W-1:0] port;
    logic [MAC_W-1:0]  mac;
  } cmd_t;

endpackage

/* sv/mlst_if.sv */
interface mlst_in_if;
  import mlst_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [PORT_W-1:0] port_index;
  logic [MAC_W-1:0]  src_mac;
  logic [MAC_W-1:0]  dest_mac;
  logic [LEN_W-1:0]  frame_length;

  modport source(output valid, kind, port_index, src_mac, dest_mac, frame_length,
                 input ready);
  modport sink(input valid, kind, port_index, src_mac, dest_mac, frame_length,
               output ready);
endinterface

interface mlst_out_if;
  import mlst_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [NUM_PORTS-1:0] port_mask;
  logic [2:0]           status;
  logic [NUM_PORTS-1:0] aged_out_mask;
  logic                 pass_up;

  modport source(output valid, port_mask, status, aged_out_mask, pass_up, input ready);
  modport sink(input valid, port_mask, status, aged_out_mask, pass_up, output ready);
endinterface

/* sv/mlst_front.sv */
module mlst_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mlst_pkg::KIND_W-1:0]   kind_i,
  input  logic [mlst_pkg::PORT_W-1:0]   port_index_i,
  input  logic [mlst_pkg::MAC_W-1:0]    src_mac_i,
  input  logic [mlst_pkg::MAC_W-1:0]    dest_mac_i,
  input  logic [mlst_pkg::LEN_W-1:0]    frame_length_i,
  output logic                          cmd_valid_o,
  output mlst_pkg::cmd_t                cmd_o,
  input  logic                          cmd_pop_i
);
  import mlst_pkg::*;

  cmd_t       dec;
  logic       runt;
  logic       bad_port;
  logic       push;
  cmd_t       queue_q [QUEUE_DEPTH];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  // classify the request
  always_comb begin
    runt     = frame_length_i < LEN_W'(MIN_FRAME_BYTES);
    bad_port = 32'(port_index_i) >= NUM_PORTS;
    dec.port = port_index_i;
    dec.mac  = src_mac_i;
    dec.runt = runt;
    dec.op   = OP_NOP;
    case (kind_i)
      KIND_TICK:   dec.op = OP_TICK;
      KIND_PORT:   dec.op = bad_port ? OP_ABSENT : OP_LEARN;
      KIND_HOST: begin
        dec.mac = dest_mac_i;
        dec.op  = runt ? OP_RUNT : OP_FLOOD;
      end
      KIND_ATTACH: dec.op = bad_port ? OP_ABSENT : OP_ATTACH;
      KIND_DETACH: dec.op = bad_port ? OP_ABSENT : OP_DETACH;
      default:     dec.op = OP_NOP;
    endcase
  end

  assign in_ready_o  = count_q < 2'(QUEUE_DEPTH);
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = count_q != 2'd0;
  assign cmd_o       = queue_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (cmd_pop_i) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(push) - 2'(cmd_pop_i);
    end
  end

endmodule

/* sv/mlst_back.sv */
module mlst_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  input  mlst_pkg::cmd_t                 cmd_i,
  output logic                           cmd_pop_o,
  input  logic                           cfg_we_i,
  input  logic [mlst_pkg::CFG_W-1:0]     cfg_wdata_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mlst_pkg::NUM_PORTS-1:0] port_mask_o,
  output logic [2:0]                     status_o,
  output logic [mlst_pkg::NUM_PORTS-1:0] aged_out_mask_o,
  output logic                           pass_up_o
);
  import mlst_pkg::*;

  typedef logic [ENTRIES_PER_PORT-1:0][MAC_W-1:0]     mac_row_t;
  typedef logic [ENTRIES_PER_PORT-1:0][TIME_BITS-1:0] exp_row_t;

  state_e state_q, state_d;
  cmd_t   cmd_q, cmd_d;
  logic [CFG_W-1:0]     expire_q;
  logic [TIME_BITS-1:0] now_q, now_d, exp_new_q;
  logic [TIME_BITS:0]   exp_sum;
  logic [NUM_PORTS-1:0] present_q, present_d, row_valid_q, row_valid_d;
  logic [PORT_W:0]      cnt_q, cnt_d;
  logic [PORT_W-1:0]    rd_row_q, rd_row_d;
  logic                 rd_pend_q, rd_pend_d;
  logic [NUM_PORTS-1:0] mask_q, mask_d, aged_q, aged_d;
  status_e              status_q, status_d;
  logic                 pass_q, pass_d;

  // row memories
  mac_row_t mac_mem [NUM_PORTS];
  exp_row_t exp_mem [NUM_PORTS];
  mac_row_t rd_mac_q;
  exp_row_t rd_exp_q;
  logic     rd_valid_q;
  logic              rd_en, wr_en;
  logic [PORT_W-1:0] rd_addr, wr_addr;
  mac_row_t          wr_mac;
  exp_row_t          wr_exp;

  mac_row_t eff_mac;
  exp_row_t eff_exp, flood_exp;
  logic [ENTRIES_PER_PORT-1:0] hit, free;
  logic                        found, have_free, live, bcast;
  logic [SLOT_W-1:0]           hit_idx, free_idx;

  logic out_valid_q;
  logic load_out;

  assign exp_sum = {1'b0, now_q} + (TIME_BITS+1)'(expire_q);

  // row evaluation
  always_comb begin
    hit_idx   = '0;
    free_idx  = '0;
    found     = 1'b0;
    have_free = 1'b0;
    live      = 1'b0;
    for (int i = 0; i < ENTRIES_PER_PORT; i++) begin
      eff_mac[i]   = rd_valid_q ? rd_mac_q[i] : '0;
      eff_exp[i]   = rd_valid_q ? rd_exp_q[i] : '0;
      hit[i]       = eff_mac[i] == cmd_q.mac;
      free[i]      = eff_exp[i] <= now_q;
      flood_exp[i] = hit[i] ? exp_new_q : eff_exp[i];
      if (flood_exp[i] > now_q) live = 1'b1;
    end
    for (int i = ENTRIES_PER_PORT - 1; i >= 0; i--) begin
      if (hit[i]) begin
        found   = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (free[i]) begin
        have_free = 1'b1;
        free_idx  = SLOT_W'(i);
      end
    end
    bcast = cmd_q.mac == BCAST_MAC;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    cmd_pop_o   = 1'b0;
    now_d       = now_q;
    present_d   = present_q;
    row_valid_d = row_valid_q;
    cnt_d       = cnt_q;
    rd_row_d    = rd_row_q;
    rd_pend_d   = 1'b0;
    mask_d      = mask_q;
    aged_d      = aged_q;
    status_d    = status_q;
    pass_d      = pass_q;
    rd_en       = 1'b0;
    rd_addr     = cmd_q.port;
    wr_en       = 1'b0;
    wr_addr     = cmd_q.port;
    wr_mac      = eff_mac;
    wr_exp      = eff_exp;
    load_out    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          mask_d    = '0;
          aged_d    = '0;
          status_d  = ST_OK;
          pass_d    = 1'b0;
          cnt_d     = '0;
          state_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_DONE;
        case (cmd_q.op)
          OP_TICK: begin
            if (now_q != TIME_MAX) now_d = now_q + TIME_BITS'(1);
          end
          OP_LEARN: begin
            if (!present_q[cmd_q.port]) begin
              status_d = ST_ABSENT;
            end else if (cmd_q.runt) begin
              status_d = ST_RUNT;
            end else begin
              rd_en   = 1'b1;
              state_d = S_LEARN;
            end
          end
          OP_FLOOD:  state_d = S_FLOOD;
          OP_ATTACH: begin
            present_d[cmd_q.port]   = 1'b1;
            row_valid_d[cmd_q.port] = 1'b0;
          end
          OP_DETACH: begin
            if (!present_q[cmd_q.port]) status_d = ST_ABSENT;
            else present_d[cmd_q.port] = 1'b0;
          end
          OP_RUNT:   status_d = ST_RUNT;
          OP_ABSENT: status_d = ST_ABSENT;
          default:   status_d = ST_OK;
        endcase
      end
      S_LEARN: begin
        pass_d  = 1'b1;
        state_d = S_DONE;
        if (found) begin
          wr_en           = 1'b1;
          wr_exp[hit_idx] = exp_new_q;
        end else if (have_free) begin
          wr_en            = 1'b1;
          wr_mac[free_idx] = cmd_q.mac;
          wr_exp[free_idx] = exp_new_q;
        end else begin
          status_d = ST_FULL;
        end
      end
      S_FLOOD: begin
        // read row cnt while row rd_row_q is evaluated
        if (cnt_q < (PORT_W+1)'(NUM_PORTS)) begin
          rd_en     = 1'b1;
          rd_addr   = cnt_q[PORT_W-1:0];
          rd_row_d  = cnt_q[PORT_W-1:0];
          rd_pend_d = 1'b1;
          cnt_d     = cnt_q + (PORT_W+1)'(1);
        end
        if (rd_pend_q && present_q[rd_row_q]) begin
          wr_en   = 1'b1;
          wr_addr = rd_row_q;
          wr_exp  = flood_exp;
          if (!live) begin
            present_d[rd_row_q] = 1'b0;
            aged_d[rd_row_q]    = 1'b1;
          end else if (found || bcast) begin
            mask_d[rd_row_q] = 1'b1;
          end
        end
        if (cnt_q == (PORT_W+1)'(NUM_PORTS) && !rd_pend_q) begin
          status_d = (mask_q == '0) ? ST_NODEST : ST_OK;
          state_d  = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (wr_en) row_valid_d[wr_addr] = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mac_mem[wr_addr] <= wr_mac;
      exp_mem[wr_addr] <= wr_exp;
    end
    if (rd_en) begin
      rd_mac_q <= mac_mem[rd_addr];
      rd_exp_q <= exp_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    rd_row_q  <= rd_row_d;
    mask_q    <= mask_d;
    aged_q    <= aged_d;
    status_q  <= status_d;
    pass_q    <= pass_d;
    exp_new_q <= exp_sum[TIME_BITS] ? TIME_MAX : exp_sum[TIME_BITS-1:0];
    if (load_out) begin
      port_mask_o     <= mask_q;
      status_o        <= status_q;
      aged_out_mask_o <= aged_q;
      pass_up_o       <= pass_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      expire_q    <= CFG_W'(DEFAULT_EXPIRE);
      now_q       <= '0;
      present_q   <= '0;
      row_valid_q <= '0;
      cnt_q       <= '0;
      rd_pend_q   <= 1'b0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      now_q       <= now_d;
      present_q   <= present_d;
      row_valid_q <= row_valid_d;
      cnt_q       <= cnt_d;
      rd_pend_q   <= rd_pend_d;
      if (cfg_we_i) expire_q <= cfg_wdata_i;
      if (rd_en) rd_valid_q <= row_valid_q[rd_addr];
      if (load_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* sv/mac_learning_switch_table.sv */
// mac learning table with aging for a small host-attached switch
//
// in_req carries one request per handshake (valid and ready both high):
// a tick, a frame from a port, a frame from the host, an attach or a detach.
// out_rsp returns exactly one response per request, in order: a port mask,
// a status, an aged-out mask and a pass-up flag.
// cfg_we_i / cfg_wdata_i write the entry lifetime in ticks; write it only
// while no request is in flight.
//
// the engine works on one request at a time: it pops the queue, executes
// the request, reads and updates the port row for a port frame, and for a
// host frame walks the table one port row per cycle through the single row
// memory read port, aging out ports and building the delivery mask; it then
// loads the response register once the sink has taken the last response.
// a two-deep request queue sits in front of the table engine, so new requests
// are taken while the engine is busy or a response waits on a stalled sink.
// reset empties the queue, clears time, ports and table, and sets the
// lifetime to 3600 ticks.
module mac_learning_switch_table (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  mlst_in_if.sink                    in_req,
  mlst_out_if.source                 out_rsp,
  input  logic                       cfg_we_i,
  input  logic [mlst_pkg::CFG_W-1:0] cfg_wdata_i
);
  import mlst_pkg::*;

  // queue to engine
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // front: decode and queue
  mlst_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_req.valid),
    .in_ready_o     (in_req.ready),
    .kind_i         (in_req.kind),
    .port_index_i   (in_req.port_index),
    .src_mac_i      (in_req.src_mac),
    .dest_mac_i     (in_req.dest_mac),
    .frame_length_i (in_req.frame_length),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_pop_i      (cmd_pop)
  );

  // back: table engine with the response register
  mlst_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd),
    .cmd_pop_o       (cmd_pop),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_valid_o     (out_rsp.valid),
    .out_ready_i     (out_rsp.ready),
    .port_mask_o     (out_rsp.port_mask),
    .status_o        (out_rsp.status),
    .aged_out_mask_o (out_rsp.aged_out_mask),
    .pass_up_o       (out_rsp.pass_up)
  );

endmodule

/* sv/mlst_checker.sv */
module mlst_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [mlst_pkg::NUM_PORTS-1:0] port_mask_i,
  input logic [2:0]                     status_i,
  input logic [mlst_pkg::NUM_PORTS-1:0] aged_out_mask_i,
  input logic                           pass_up_i
);
  import mlst_pkg::*;

  // stalled response holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(port_mask_i) && $stable(status_i))
    else $error("stalled response changed");

  // only port frames pass up, and only when learned or table full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && pass_up_i |-> status_i == ST_OK || status_i == ST_FULL)
    else $error("pass up with bad status");

  // a delivered frame is ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && port_mask_i != '0 |-> status_i == ST_OK && !pass_up_i)
    else $error("delivery with bad status");

  // an aged-out port never receives the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (port_mask_i & aged_out_mask_i) == '0)
    else $error("aged port in delivery mask");

endmodule

bind mac_learning_switch_table mlst_checker u_mlst_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_rsp.valid),
  .out_ready_i     (out_rsp.ready),
  .port_mask_i     (out_rsp.port_mask),
  .status_i        (out_rsp.status),
  .aged_out_mask_i (out_rsp.aged_out_mask),
  .pass_up_i       (out_rsp.pass_up)
);
